[src/olsr_pkg.sv]
// ============================================================================
// olsr_pkg
// Shared types and codes for the ordered list with search and remove.
// ============================================================================
package olsr_pkg;

  // Operation codes carried in the kind field
  localparam logic [1:0] K_APPEND = 2'd0;
  localparam logic [1:0] K_POP    = 2'd1;
  localparam logic [1:0] K_REMOVE = 2'd2;
  localparam logic [1:0] K_QUERY  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam int unsigned VALUE_W = 32;

  // Request payload
  typedef struct packed {
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  // Response payload
  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic                      found;
    logic [4:0]                count;
    logic [1:0]                status;
  } rsp_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    logic                      do_append;
    logic                      do_pop;
    logic                      do_search;
    logic                      take;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage

[src/olsr_ram.sv]
// ============================================================================
// olsr_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module olsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; hold data when no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/olsr_front.sv]
// ============================================================================
// olsr_front
// Request intake: classify each request and hold it in a two-entry queue.
// ============================================================================
module olsr_front
  import olsr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  cmd_t       q_data [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_cnt;
  logic       push;
  logic       pop;
  cmd_t       cls;

  // Decode the operation into command flags
  always_comb begin
    cls           = '0;
    cls.value     = req.value;
    case (req.kind)
      K_APPEND: cls.do_append = 1'b1;
      K_POP:    cls.do_pop    = 1'b1;
      K_REMOVE: begin
        cls.do_search = 1'b1;
        cls.take      = 1'b1;
      end
      default:  cls.do_search = 1'b1;
    endcase
  end

  assign req_ready = (q_cnt != 2'd2);
  assign cmd_valid = (q_cnt != 2'd0);
  assign cmd       = q_data[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = cmd_valid && cmd_ready;

  // Store an accepted transfer
  always_ff @(posedge clk) begin
    if (push) begin
      q_data[wr_ptr] <= cls;
    end
  end

  // Advance queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        q_cnt <= q_cnt + 2'd1;
      end else if (pop && !push) begin
        q_cnt <= q_cnt - 2'd1;
      end
    end
  end

endmodule

[src/olsr_back.sv]
// ============================================================================
// olsr_back
// Command execution over a circular entry store, plus the response register.
// ============================================================================
module olsr_back
  import olsr_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  logic [1:0]         state, state_next;
  cmd_t               cur, cur_next;
  logic [AW-1:0]      head, head_next;
  logic [AW-1:0]      tail, tail_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [AW-1:0]      scan_ptr, scan_ptr_next;
  logic [AW-1:0]      cmp_ptr, cmp_ptr_next;
  logic [CW-1:0]      cmp_idx, cmp_idx_next;
  logic [AW-1:0]      dst, dst_next;
  logic [AW-1:0]      src, src_next;
  logic [CW-1:0]      left, left_next;
  logic               pend, pend_next;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic               fin;
  rsp_t               res;
  logic               slot_free;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
  endfunction

  olsr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Response slot is empty next cycle
  assign slot_free = !rsp_valid || rsp_ready;

  // Sequencer: append, pop, pipelined scan, then close-up shift on remove
  always_comb begin
    state_next    = state;
    cur_next      = cur;
    head_next     = head;
    tail_next     = tail;
    cnt_next      = cnt;
    scan_ptr_next = scan_ptr;
    cmp_ptr_next  = cmp_ptr;
    cmp_idx_next  = cmp_idx;
    dst_next      = dst;
    src_next      = src;
    left_next     = left;
    pend_next     = pend;
    ram_we        = 1'b0;
    ram_waddr     = tail;
    ram_wdata     = $unsigned(cmd.value);
    ram_re        = 1'b0;
    ram_raddr     = head;
    cmd_ready     = 1'b0;
    fin           = 1'b0;
    res           = '0;
    res.status    = ST_OK;

    case (state)
      S_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_ready = 1'b1;
          cur_next  = cmd;
          if (cmd.do_append) begin
            fin = 1'b1;
            if (cnt == CW'(DEPTH)) begin
              res.status = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              tail_next = ptr_inc(tail);
              cnt_next  = cnt + 1'b1;
            end
          end else if (cmd.do_pop) begin
            if (cnt == '0) begin
              fin        = 1'b1;
              res.status = ST_EMPTY;
            end else begin
              ram_re     = 1'b1;
              state_next = S_POP;
            end
          end else begin
            if (cnt == '0) begin
              fin        = 1'b1;
              res.status = ST_MISSING;
            end else begin
              ram_re        = 1'b1;
              scan_ptr_next = ptr_inc(head);
              cmp_ptr_next  = head;
              cmp_idx_next  = '0;
              state_next    = S_SCAN;
            end
          end
        end
      end

      S_POP: begin
        fin           = 1'b1;
        res.out_value = $signed(ram_rdata);
        head_next     = ptr_inc(head);
        cnt_next      = cnt - 1'b1;
        state_next    = S_IDLE;
      end

      S_SCAN: begin
        if (ram_rdata == $unsigned(cur.value)) begin
          if (cur.take) begin
            dst_next   = cmp_ptr;
            src_next   = ptr_inc(cmp_ptr);
            left_next  = cnt - 1'b1 - cmp_idx;
            pend_next  = 1'b0;
            state_next = S_SHIFT;
          end else begin
            fin        = 1'b1;
            res.found  = 1'b1;
            state_next = S_IDLE;
          end
        end else if (cmp_idx == cnt - 1'b1) begin
          fin        = 1'b1;
          res.status = ST_MISSING;
          state_next = S_IDLE;
        end else begin
          ram_re        = 1'b1;
          ram_raddr     = scan_ptr;
          scan_ptr_next = ptr_inc(scan_ptr);
          cmp_ptr_next  = scan_ptr;
          cmp_idx_next  = cmp_idx + 1'b1;
        end
      end

      S_SHIFT: begin
        // Write back the entry read last cycle one place nearer the head
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = dst;
          ram_wdata = ram_rdata;
          dst_next  = ptr_inc(dst);
        end
        if (left != '0) begin
          ram_re    = 1'b1;
          ram_raddr = src;
          src_next  = ptr_inc(src);
          left_next = left - 1'b1;
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (left == '0 && !pend) begin
          fin        = 1'b1;
          res.found  = 1'b1;
          cnt_next   = cnt - 1'b1;
          tail_next  = ptr_dec(tail);
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    res.count = 5'(cnt_next);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
    end
  end

  // Working registers of the current command
  always_ff @(posedge clk) begin
    cur      <= cur_next;
    scan_ptr <= scan_ptr_next;
    cmp_ptr  <= cmp_ptr_next;
    cmp_idx  <= cmp_idx_next;
    dst      <= dst_next;
    src      <= src_next;
    left     <= left_next;
  end

  // Response register: load on completion, drop once the transfer is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      rsp <= res;
    end
  end

  // Occupancy never exceeds the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above depth");

  // A busy sequencer always works on a non-empty store
  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> cnt != '0)
    else $error("sequencer busy on empty store");

  // Completion never overwrites a response still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    fin |-> slot_free)
    else $error("response overwritten");

  // A found flag only comes with an ok status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> rsp.status == ST_OK)
    else $error("found with bad status");

  // Full report only when the store really is full
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    fin && res.status == ST_FULL |-> cnt == CW'(DEPTH))
    else $error("full reported below depth");

endmodule

[src/ordered_list_with_search_remove_unit.sv]
// ============================================================================
// ordered_list_with_search_remove_unit
// Bounded insertion-ordered store of signed 32-bit values with search/remove.
// ============================================================================
// Usage:
//   req channel (req_valid/req_ready/req) carries one operation per transfer:
//   append at the tail, pop the head, remove the first equal entry, or query
//   whether a value is present. rsp channel (rsp_valid/rsp_ready/rsp) returns
//   exactly one response per request, in request order.
//   A two-entry request queue takes transfers while the store is busy or a
//   response waits in the output register.
//   Handling of a request once it reaches the sequencer:
//     append, and any empty/full/empty-search case: answered from idle
//     pop: one registered store read, then the response
//     query or failed remove: a scan from the head over up to N stored entries (one entry read
//     and compared per cycle on the single store read port)
//     successful remove: a scan up to the match, then a close-up shift that
//     moves each later entry one place nearer the head (none for the tail).
//   The sequencer starts a request only when the output register is free, so
//   a stalled receiver holds the store; requests then queue until it is full.
//   Reset empties the store at once; entry contents need no clearing.
// ============================================================================
module ordered_list_with_search_remove_unit
  import olsr_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  olsr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  olsr_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
